// File: design/fixed_key_aes_tweak_hash_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the fixed-key AES tweak hash
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// -----------------------------------------------------------------------------
`ifndef FIXED_KEY_AES_TWEAK_HASH_DEFINES_SVH
`define FIXED_KEY_AES_TWEAK_HASH_DEFINES_SVH

// Property holds in the same cycle as its antecedent.
`define FKA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fka assertion failed");

// Consequent checked in the cycle after the antecedent.
`define FKA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fka assertion failed");

`endif

// File: design/fka_pkg.sv
// -----------------------------------------------------------------------------
// fka_pkg
// Constants, S-box and round functions for the fixed-key AES tweak hash.
// -----------------------------------------------------------------------------
package fka_pkg;

  localparam int NumRounds = 10;
  localparam int NumCells  = NumRounds + 1;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  localparam logic [1:0] ModeInit  = 2'd0;
  localparam logic [1:0] ModeRound = 2'd1;
  localparam logic [1:0] ModeLast  = 2'd2;

  typedef struct packed {
    logic load;
    logic valid;
  } cell_ctl_t;

  typedef logic [NumCells-1:0][127:0] round_keys_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows and optionally MixColumns; byte j sits at bits 8j+7..8j.
  function automatic logic [127:0] aes_round(logic [127:0] s, logic mix);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = Sbox[s[8*(r + 4*((c + r) & 3)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = t[4*c];
      a1  = t[4*c+1];
      a2  = t[4*c+2];
      a3  = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (mix) begin
        o[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
        o[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
        o[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
        o[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end else begin
        o[8*(4*c)   +: 8] = a0;
        o[8*(4*c+1) +: 8] = a1;
        o[8*(4*c+2) +: 8] = a2;
        o[8*(4*c+3) +: 8] = a3;
      end
    end
    return o;
  endfunction

endpackage

// File: design/fixed_key_aes_tweak_hash.sv
// Each accepted word passes through every round cell register to hash word valid; one word per cycle unless
// out_ready_i low or a key expansion holds the flow. The chain has 11 round cells: the first adds the initial key.
// Stalls collapse bubbles: a cell loads whenever it is empty or its successor moves.
// Reset: key clears to zero; the schedule then expands with in_ready_o low.
// Each key write reruns the same expansion before the next word is taken.
// -----------------------------------------------------------------------------
// fixed_key_aes_tweak_hash
// Tweakable hash: m = block ^ {tweak,tweak}, hash = m ^ AES128_k(m).
// -----------------------------------------------------------------------------
`include "fixed_key_aes_tweak_hash_defines.svh"

module fixed_key_aes_tweak_hash import fka_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        block_high_i,
  input  logic [63:0]        block_low_i,
  input  logic [63:0]        tweak_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        hash_high_o,
  output logic [63:0]        hash_low_o
);

  logic                      key_busy;
  round_keys_t               round_keys;
  logic [NumCells:0]         adv;
  logic [NumCells-1:0]       cell_valid;
  logic [NumCells-1:0][127:0] cell_state, cell_mask;
  logic [127:0]              masked;

  fka_key_expand u_key (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .busy_o       (key_busy),
    .round_keys_o (round_keys)
  );

  // Apply the tweak to both halves up front.
  assign masked = {block_high_i ^ tweak_index_i, block_low_i ^ tweak_index_i};

  // Ready ripples back from the output: a cell moves if empty or if its successor moves.
  always_comb begin
    adv[NumCells] = out_ready_i;
    for (int k = NumCells - 1; k >= 0; k--) begin
      adv[k] = !cell_valid[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0] && !key_busy;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    cell_ctl_t  ctl;
    logic [1:0] mode;

    if (k == 0) begin : g_head
      assign ctl.valid = in_valid_i && !key_busy;
      assign mode      = ModeInit;
    end else begin : g_body
      assign ctl.valid = cell_valid[k-1];
      assign mode      = (k == NumCells - 1) ? ModeLast : ModeRound;
    end
    assign ctl.load = adv[k];

    fka_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (mode),
      .ctl_i   (ctl),
      .state_i ((k == 0) ? masked : cell_state[(k == 0) ? 0 : k-1]),
      .mask_i  ((k == 0) ? masked : cell_mask[(k == 0) ? 0 : k-1]),
      .rkey_i  (round_keys[k]),
      .valid_o (cell_valid[k]),
      .state_o (cell_state[k]),
      .mask_o  (cell_mask[k])
    );
  end

  // Final cell doubles as the output register; fold the mask back in here.
  assign out_valid_o = cell_valid[NumCells-1];
  assign hash_high_o = cell_mask[NumCells-1][127:64] ^ cell_state[NumCells-1][127:64];
  assign hash_low_o  = cell_mask[NumCells-1][63:0]   ^ cell_state[NumCells-1][63:0];

  `FKA_ASSERT(a_no_accept_while_expanding, clk_i, rst_ni, (in_valid_i && in_ready_o) |-> !key_busy)
  `FKA_ASSERT_NEXT(a_write_starts_expand, clk_i, rst_ni, cfg_we_i, key_busy && !in_ready_o)
  `FKA_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

endmodule

// File: design/fka_round_cell.sv
// -----------------------------------------------------------------------------
// fka_round_cell
// Key add or AES round per mode; holds state and mask, hands both onward.
// -----------------------------------------------------------------------------
module fka_round_cell import fka_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   mode_i,
  input  cell_ctl_t    ctl_i,
  input  logic [127:0] state_i,
  input  logic [127:0] mask_i,
  input  logic [127:0] rkey_i,
  output logic         valid_o,
  output logic [127:0] state_o,
  output logic [127:0] mask_o
);

  logic         valid_q;
  logic [127:0] state_d, state_q, mask_q;

  always_comb begin
    unique case (mode_i)
      ModeInit:  state_d = state_i ^ rkey_i;
      ModeRound: state_d = aes_round(state_i, 1'b1) ^ rkey_i;
      ModeLast:  state_d = aes_round(state_i, 1'b0) ^ rkey_i;
      default:   state_d = state_i ^ rkey_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= ctl_i.valid;
    end
  end

  // advance payload with the stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      state_q <= state_d;
      mask_q  <= mask_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign mask_o  = mask_q;

endmodule

// File: design/fka_key_expand.sv
// -----------------------------------------------------------------------------
// fka_key_expand
// Key registers and round key schedule, one round key per cycle after a write or reset while no further write arrives.
// -----------------------------------------------------------------------------
module fka_key_expand import fka_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  output logic               busy_o,
  output round_keys_t        round_keys_o
);

  logic [63:0]  key_high_q, key_low_q;
  logic         busy_q;
  logic [3:0]   cnt_q;
  logic [127:0] prev_q, next_key;
  round_keys_t  rk_q;

  function automatic logic [127:0] next_rk(logic [127:0] k, logic [7:0] rc);
    logic [31:0]  t;
    logic [127:0] o;
    t = {Sbox[k[103:96]], Sbox[k[127:120]], Sbox[k[119:112]],
         Sbox[k[111:104]] ^ rc};
    o[31:0]   = k[31:0]   ^ t;
    o[63:32]  = k[63:32]  ^ o[31:0];
    o[95:64]  = k[95:64]  ^ o[63:32];
    o[127:96] = k[127:96] ^ o[95:64];
    return o;
  endfunction

  assign next_key = next_rk(prev_q, Rcon[cnt_q - 4'd1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      busy_q     <= 1'b1;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegKeyHigh: key_high_q <= cfg_data_i;
          RegKeyLow:  key_low_q  <= cfg_data_i;
          default:    ;
        endcase
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(NumRounds)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_we_i) begin
      if (cnt_q == 4'd0) begin
        prev_q   <= {key_high_q, key_low_q};
        rk_q[0]  <= {key_high_q, key_low_q};
      end else begin
        prev_q       <= next_key;
        rk_q[cnt_q]  <= next_key;
      end
    end
  end

  assign busy_o       = busy_q;
  assign round_keys_o = rk_q;

endmodule
